/* design/tsm_pkg.sv */
package tsm_pkg;

  // fixed field widths
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 11;
  localparam int CNT_W     = 10;
  localparam int OUT_CNT_W = 9;
  localparam int SEL_W     = 2;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 56;

  // defaults for the top-level parameters
  localparam int DEPTH_DEF  = 1024;
  localparam int DATA_W_DEF = 32;

  localparam int CAP_RST = 1024;
  localparam int CAP_MIN = 3;

  localparam logic [SEL_W-1:0] SEL_BAD = 2'd3;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic take;
  } cmd_t;

endpackage

/* design/tsm_ctrl.sv */
module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  input  logic m_tready_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_RESP;
      end
      S_RESP: begin
        if (m_tready_i && !s_tvalid_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: a new request may enter as the held result leaves
  always_comb begin
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
      end
      S_RESP: begin
        s_tready_o = m_tready_i;
        m_tvalid_o = 1'b1;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
    cmd_o.take = s_tvalid_i && s_tready_o;
  end

endmodule

/* design/tsm_dp.sv */
module tsm_dp
  import tsm_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic                 action_i,
  input  logic [SEL_W-1:0]     stack_sel_i,
  input  logic [VAL_W-1:0]     push_value_i,
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_wdata_i,
  output logic                 status_o,
  output logic [VAL_W-1:0]     pop_value_o,
  output logic                 is_empty_o,
  output logic                 is_full_o,
  output logic [OUT_CNT_W-1:0] count_o,
  output logic [OUT_CNT_W-1:0] share_o
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RST_CAP = (DEPTH < CAP_RST) ? DEPTH : CAP_RST;
  localparam int RST_B1  = RST_CAP / 3;
  localparam int RST_B2  = (2 * RST_CAP) / 3;

  // exact x/3 for x below 2^16
  function automatic logic [CAP_W-1:0] div3(input logic [CAP_W:0] x);
    logic [CAP_W+16:0] p;
    p = {5'd0, x} * 28'd43691;
    return CAP_W'(p >> 17);
  endfunction

  logic [CAP_W-1:0] base1_q, base2_q;
  logic [CNT_W-1:0] size_q [3];
  logic [CNT_W-1:0] count_q [3];

  logic [CAP_W-1:0] cap_clamp, b1_new, b2_new;

  always_comb begin
    cap_clamp = cfg_wdata_i;
    if (cfg_wdata_i < CAP_W'(CAP_MIN)) begin
      cap_clamp = CAP_W'(CAP_MIN);
    end else if (32'(cfg_wdata_i) > DEPTH) begin
      cap_clamp = CAP_W'(DEPTH);
    end
    b1_new = div3({1'b0, cap_clamp});
    b2_new = div3({cap_clamp, 1'b0});
  end

  // selected stack
  logic             sel_ok;
  logic [CNT_W-1:0] cnt_sel, size_sel, cnt_new;
  logic [CAP_W-1:0] base_sel, addr_sum;
  logic             push_ok, pop_ok;

  always_comb begin
    sel_ok   = 1'b1;
    cnt_sel  = count_q[0];
    size_sel = size_q[0];
    base_sel = '0;
    case (stack_sel_i)
      2'd0: begin
        cnt_sel  = count_q[0];
        size_sel = size_q[0];
        base_sel = '0;
      end
      2'd1: begin
        cnt_sel  = count_q[1];
        size_sel = size_q[1];
        base_sel = base1_q;
      end
      2'd2: begin
        cnt_sel  = count_q[2];
        size_sel = size_q[2];
        base_sel = base2_q;
      end
      default: sel_ok = 1'b0;
    endcase

    push_ok = sel_ok && (action_i == ACT_PUSH) && (cnt_sel < size_sel);
    pop_ok  = sel_ok && (action_i == ACT_POP) && (cnt_sel != '0);

    cnt_new = cnt_sel;
    if (push_ok) cnt_new = cnt_sel + CNT_W'(1);
    if (pop_ok)  cnt_new = cnt_sel - CNT_W'(1);

    // top of stack after a push, or the current top word on a pop
    addr_sum = base_sel + CAP_W'(cnt_sel);
    if (pop_ok) addr_sum = addr_sum - CAP_W'(1);
  end

  logic [AW-1:0] addr;
  assign addr = AW'(addr_sum);

  // segment bounds and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base1_q    <= CAP_W'(RST_B1);
      base2_q    <= CAP_W'(RST_B2);
      size_q[0]  <= CNT_W'(RST_B1);
      size_q[1]  <= CNT_W'(RST_B2 - RST_B1);
      size_q[2]  <= CNT_W'(RST_CAP - RST_B2);
      count_q[0] <= '0;
      count_q[1] <= '0;
      count_q[2] <= '0;
    end else if (cfg_we_i) begin
      base1_q    <= b1_new;
      base2_q    <= b2_new;
      size_q[0]  <= CNT_W'(b1_new);
      size_q[1]  <= CNT_W'(b2_new - b1_new);
      size_q[2]  <= CNT_W'(cap_clamp - b2_new);
      count_q[0] <= '0;
      count_q[1] <= '0;
      count_q[2] <= '0;
    end else if (cmd_i.take && (push_ok || pop_ok)) begin
      case (stack_sel_i)
        2'd0:    count_q[0] <= cnt_new;
        2'd1:    count_q[1] <= cnt_new;
        2'd2:    count_q[2] <= cnt_new;
        default: count_q[0] <= count_q[0];
      endcase
    end
  end

  // word store, one port
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && push_ok) begin
      mem_q[addr] <= DATA_W'(push_value_i);
    end
    if (cmd_i.take && pop_ok) begin
      rd_data_q <= mem_q[addr];
    end
  end

  // result register
  logic                 res_status_q, res_pop_ok_q, res_empty_q, res_full_q;
  logic [OUT_CNT_W-1:0] res_cnt_q, res_share_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pop_ok_q <= 1'b0;
      res_full_q   <= 1'b0;
    end else if (cmd_i.take) begin
      res_pop_ok_q <= pop_ok;
      res_full_q   <= sel_ok ? (cnt_new >= size_sel) : 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_status_q <= !(push_ok || pop_ok);
      res_empty_q  <= sel_ok ? (cnt_new == '0) : 1'b1;
      res_cnt_q    <= sel_ok ? OUT_CNT_W'(cnt_new) : '0;
      res_share_q  <= sel_ok ? OUT_CNT_W'(size_sel) : '0;
    end
  end

  assign status_o    = res_status_q;
  assign pop_value_o = res_pop_ok_q ? VAL_W'(rd_data_q) : '0;
  assign is_empty_o  = res_empty_q;
  assign is_full_o   = res_full_q;
  assign count_o     = res_cnt_q;
  assign share_o     = res_share_q;

`ifndef SYNTHESIS
  a_count_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[0] <= size_q[0] && count_q[1] <= size_q[1] && count_q[2] <= size_q[2])
    else $error("stack count beyond its segment");

  a_cfg_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> count_q[0] == '0 && count_q[1] == '0 && count_q[2] == '0)
    else $error("capacity write did not empty the stacks");

  a_bad_sel_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && stack_sel_i == SEL_BAD |=>
      res_status_q && res_cnt_q == '0 && res_share_q == '0 && !res_pop_ok_q)
    else $error("invalid selector not rejected");

  a_pop_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_pop_ok_q |-> !res_full_q)
    else $error("stack full after a pop");
`endif

endmodule

/* design/three_stacks_one_memory_unit.sv */
// three stacks sharing one word memory, split into three near-equal segments
// input channel s_axis: tdata carries the word to push, tuser the action
//   (push or pop) and the stack selector; one request per handshake
// output channel m_axis: one result per request with status in tuser and
//   popped word, empty, full, count and segment size in tdata
// capacity is set via cfg_we_i / cfg_wdata_i, by the user only while no
//   request is in flight (not enforced by the block); a write empties all
//   three stacks, values are clamped to 3..DEPTH and memory is not cleared
// the result is valid in the cycle after the request is taken
// throughput: one request per cycle while the result side keeps tready
//   high; a new request is taken in the same cycle that the held result
//   leaves, the single memory port being read or written once per request
// when the receiver stalls the result is held and s_axis_tready stays low
// reset: all stacks empty, capacity min(1024, DEPTH), no result pending
module three_stacks_one_memory_unit
  import tsm_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,  // push_value
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // action, stack_sel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pop_value, is_empty, is_full, count, share, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,  // status
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i
);

  cmd_t                 cmd;
  logic                 status, is_empty, is_full;
  logic [VAL_W-1:0]     pop_value;
  logic [OUT_CNT_W-1:0] count, share;

  tsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  tsm_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (s_axis_tuser[0]),
    .stack_sel_i  (s_axis_tuser[2:1]),
    .push_value_i (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .status_o     (status),
    .pop_value_o  (pop_value),
    .is_empty_o   (is_empty),
    .is_full_o    (is_full),
    .count_o      (count),
    .share_o      (share)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {4'd0, share, count, is_full, is_empty, pop_value};

endmodule
